// ----- rtl/tooth_period_wheel_speed_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Tooth period wheel speed unit: assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef TOOTH_PERIOD_WHEEL_SPEED_UNIT_MACROS_SVH
`define TOOTH_PERIOD_WHEEL_SPEED_UNIT_MACROS_SVH

// same-cycle implication
`define TPWS_ASSERT_IMP(lbl, clk, rstn, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
		else $error("tpws assertion failed");

// next-cycle implication
`define TPWS_ASSERT_NXT(lbl, clk, rstn, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
		else $error("tpws assertion failed");

`endif

// ----- rtl/tpws_pkg.sv -----
// ----------------------------------------------------------------------------
// Tooth period wheel speed: package
// Types, widths and codes shared by the speed unit modules.
// ----------------------------------------------------------------------------
package tpws_pkg;

	localparam int NUM_WHEELS      = 2;
	localparam int SPEED_FRAC_BITS = 4;
	localparam int TPM_W           = 28;
	localparam int TEETH_W         = 8;
	localparam int MS_CFG_W        = 16;
	localparam int CAP_W           = 16;
	localparam int MS_W            = 32;
	localparam int SPEED_W         = 32;
	localparam int NUM_W           = TPM_W + SPEED_FRAC_BITS;
	localparam int DEN_W           = TEETH_W + CAP_W;
	localparam int DIV_CNT_W       = $clog2(NUM_W + 1);
	localparam int ADDR_W          = 4;
	localparam int DATA_W          = 32;

	localparam logic MODE_CAPTURE = 1'b0;
	localparam logic MODE_READ    = 1'b1;

	localparam logic [1:0] REG_TICKS_PER_MINUTE = 2'd0;
	localparam logic [1:0] REG_TEETH_COUNT      = 2'd1;
	localparam logic [1:0] REG_MAX_GAP_MS       = 2'd2;
	localparam logic [1:0] REG_STANDSTILL_MS    = 2'd3;

	localparam logic [TPM_W-1:0]    RST_TICKS_PER_MINUTE = TPM_W'(60000000);
	localparam logic [TEETH_W-1:0]  RST_TEETH_COUNT      = TEETH_W'(20);
	localparam logic [MS_CFG_W-1:0] RST_MAX_GAP_MS       = MS_CFG_W'(60);
	localparam logic [MS_CFG_W-1:0] RST_STANDSTILL_MS    = MS_CFG_W'(300);

	typedef struct packed {
		logic             mode;
		logic             wheel_index;
		logic [CAP_W-1:0] capture_value;
		logic [MS_W-1:0]  now_ms;
	} item_t;

	typedef struct packed {
		logic [SPEED_W-1:0] speed_sixteenths;
		logic               speed_wheel;
	} result_t;

	typedef struct packed {
		logic [TPM_W-1:0]    ticks_per_minute;
		logic [TEETH_W-1:0]  teeth_count;
		logic [MS_CFG_W-1:0] max_gap_ms;
		logic [MS_CFG_W-1:0] standstill_ms;
	} cfg_t;

	typedef struct packed {
		logic latch_item;
		logic update_ts;
		logic zero_speed;
		logic div_start;
		logic write_speed;
		logic load_result;
	} dp_cmd_t;

	typedef struct packed {
		logic in_is_read;
		logic zero_case;
		logic skip_div;
		logic div_busy;
		logic out_free;
	} dp_sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_CAP_EVAL,
		ST_DIV_WAIT,
		ST_READ
	} state_t;

endpackage

// ----- rtl/tpws_cfg.sv -----
// ----------------------------------------------------------------------------
// Tooth period wheel speed: configuration registers
// APB-style register file, zero wait states.
// ----------------------------------------------------------------------------
module tpws_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tpws_pkg::ADDR_W-1:0] paddr,
	input  logic [tpws_pkg::DATA_W-1:0] pwdata,
	output logic [tpws_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output tpws_pkg::cfg_t             cfg
);
	import tpws_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_minute <= RST_TICKS_PER_MINUTE;
			cfg_q.teeth_count      <= RST_TEETH_COUNT;
			cfg_q.max_gap_ms       <= RST_MAX_GAP_MS;
			cfg_q.standstill_ms    <= RST_STANDSTILL_MS;
		end else if (wr_en) begin
			case (reg_idx)
				REG_TICKS_PER_MINUTE: cfg_q.ticks_per_minute <= pwdata[TPM_W-1:0];
				REG_TEETH_COUNT:      cfg_q.teeth_count      <= pwdata[TEETH_W-1:0];
				REG_MAX_GAP_MS:       cfg_q.max_gap_ms       <= pwdata[MS_CFG_W-1:0];
				REG_STANDSTILL_MS:    cfg_q.standstill_ms    <= pwdata[MS_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TICKS_PER_MINUTE: prdata = DATA_W'(cfg_q.ticks_per_minute);
			REG_TEETH_COUNT:      prdata = DATA_W'(cfg_q.teeth_count);
			REG_MAX_GAP_MS:       prdata = DATA_W'(cfg_q.max_gap_ms);
			REG_STANDSTILL_MS:    prdata = DATA_W'(cfg_q.standstill_ms);
			default:              prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/tpws_div.sv -----
// ----------------------------------------------------------------------------
// Tooth period wheel speed: iterative divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpws_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tpws_pkg::NUM_W-1:0]  num,
	input  logic [tpws_pkg::DEN_W-1:0]  den,
	output logic                        busy,
	output logic [tpws_pkg::NUM_W-1:0]  quot
);
	import tpws_pkg::*;

	logic [DIV_CNT_W-1:0] count_q;
	logic [DEN_W-1:0]     den_q;
	logic [DEN_W-1:0]     rem_q;
	logic [NUM_W-1:0]     quot_q;
	logic [DEN_W:0]       shifted;
	logic [DEN_W:0]       diff;
	logic                 fits;

	// remainder stays below den, so one extra bit covers the shifted value
	assign shifted = {rem_q, quot_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = ~diff[DEN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (start) begin
			count_q <= DIV_CNT_W'(NUM_W);
		end else if (count_q != '0) begin
			count_q <= count_q - DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= num;
		end else if (count_q != '0) begin
			rem_q  <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quot_q <= {quot_q[NUM_W-2:0], fits};
		end
	end

	assign busy = (count_q != '0);
	assign quot = quot_q;

endmodule

// ----- rtl/tpws_ctrl.sv -----
// ----------------------------------------------------------------------------
// Tooth period wheel speed: controller
// Sequences one request at a time through the datapath.
// ----------------------------------------------------------------------------
module tpws_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  tpws_pkg::dp_sts_t sts,
	output tpws_pkg::dp_cmd_t cmd
);
	import tpws_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				state_d = sts.in_is_read ? ST_READ : ST_CAP_EVAL;
			end
			ST_CAP_EVAL: begin
				if (sts.zero_case || sts.skip_div) state_d = ST_IDLE;
				else state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (!sts.div_busy) state_d = ST_IDLE;
			end
			ST_READ: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready     = 1'b1;
				cmd.latch_item = item_valid;
			end
			ST_DISPATCH: ;
			ST_CAP_EVAL: begin
				cmd.update_ts  = 1'b1;
				cmd.zero_speed = sts.zero_case;
				cmd.div_start  = ~sts.zero_case & ~sts.skip_div;
			end
			ST_DIV_WAIT: begin
				cmd.write_speed = ~sts.div_busy;
			end
			ST_READ: begin
				cmd.load_result = sts.out_free;
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/tpws_dp.sv -----
// ----------------------------------------------------------------------------
// Tooth period wheel speed: datapath
// Per-wheel state, gap and delta arithmetic, divider and result register.
// ----------------------------------------------------------------------------
module tpws_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  tpws_pkg::item_t   item,
	input  tpws_pkg::cfg_t    cfg,
	input  tpws_pkg::dp_cmd_t cmd,
	output tpws_pkg::dp_sts_t sts,
	output logic              result_valid,
	input  logic              result_ready,
	output tpws_pkg::result_t result
);
	import tpws_pkg::*;

	item_t              item_q;
	logic [CAP_W-1:0]   prev_cap_q [NUM_WHEELS];
	logic               await_q    [NUM_WHEELS];
	logic [MS_W-1:0]    last_ms_q  [NUM_WHEELS];
	logic [SPEED_W-1:0] speed_q    [NUM_WHEELS];
	logic               res_valid_q;
	result_t            result_q;

	logic               w;
	logic               in_range;
	logic [MS_W-1:0]    age;
	logic [CAP_W-1:0]   delta;
	logic [DEN_W-1:0]   den;
	logic [NUM_W-1:0]   num;
	logic [NUM_W-1:0]   quot;
	logic               div_busy;
	logic [SPEED_W-1:0] read_speed;

	assign w        = item_q.wheel_index;
	assign in_range = (int'(w) < NUM_WHEELS);
	assign age      = item_q.now_ms - last_ms_q[w];
	assign delta    = item_q.capture_value - prev_cap_q[w];
	assign den      = DEN_W'(cfg.teeth_count) * DEN_W'(delta);
	assign num      = NUM_W'(cfg.ticks_per_minute) << SPEED_FRAC_BITS;

	tpws_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num),
		.den    (den),
		.busy   (div_busy),
		.quot   (quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch_item) item_q <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WHEELS; i++) begin
				prev_cap_q[i] <= '0;
				await_q[i]    <= 1'b1;
				last_ms_q[i]  <= '0;
				speed_q[i]    <= '0;
			end
		end else if (in_range) begin
			if (cmd.update_ts) begin
				prev_cap_q[w] <= item_q.capture_value;
				last_ms_q[w]  <= item_q.now_ms;
				await_q[w]    <= 1'b0;
			end
			if (cmd.zero_speed) speed_q[w] <= '0;
			// numerator fits in NUM_W bits, so the quotient never needs clamping
			if (cmd.write_speed) speed_q[w] <= SPEED_W'(quot);
		end
	end

	assign read_speed = (in_range && age <= MS_W'(cfg.standstill_ms)) ? speed_q[w] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			result_q.speed_sixteenths <= read_speed;
			result_q.speed_wheel      <= w;
		end
	end

	assign sts.in_is_read = (item_q.mode == MODE_READ);
	assign sts.zero_case  = in_range && (await_q[w] || age > MS_W'(cfg.max_gap_ms));
	assign sts.skip_div   = !in_range || delta == '0 || cfg.teeth_count == '0;
	assign sts.div_busy   = div_busy;
	assign sts.out_free   = ~res_valid_q | result_ready;

	assign result_valid = res_valid_q;
	assign result       = result_q;

endmodule

// ----- rtl/tooth_period_wheel_speed_unit.sv -----
// ----------------------------------------------------------------------------
// Tooth period wheel speed unit: top level
// Usage:
//   item channel (item_valid/item_ready/item) takes tooth capture events
//   (mode 0) and speed read requests (mode 1) for one of two wheels.
//   result channel (result_valid/result_ready/result) returns one speed
//   per read request, in 1/16 RPM; captures return nothing.
//   APB port sets ticks_per_minute, teeth_count, max_gap_ms, standstill_ms.
// Timing: one request in flight at a time.
//   read: accept, dispatch, then the result is registered once the output
//   register is free; the next request is accepted after that.
//   capture: accept, dispatch, evaluate; it ends there when speed is zeroed or kept,
//   otherwise the restoring divider resolves one of 32 quotient bits per cycle.
// Reset: registers take their defaults, every wheel waits for a first pulse
//   with speed 0, no result pending.
// Stall: a result waits in the output register; the unit still accepts the
//   next request, and a following read holds until the register frees.
// ----------------------------------------------------------------------------
module tooth_period_wheel_speed_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  tpws_pkg::item_t             item,
	output logic                        result_valid,
	input  logic                        result_ready,
	output tpws_pkg::result_t           result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tpws_pkg::ADDR_W-1:0] paddr,
	input  logic [tpws_pkg::DATA_W-1:0] pwdata,
	output logic [tpws_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import tpws_pkg::*;

	cfg_t    cfg;
	dp_cmd_t cmd;
	dp_sts_t sts;

	tpws_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tpws_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	tpws_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ----- rtl/tpws_checker.sv -----
// ----------------------------------------------------------------------------
// Tooth period wheel speed: port checker
// Watches the top-level ports; bound to the top level below.
// ----------------------------------------------------------------------------
`include "tooth_period_wheel_speed_unit_macros.svh"

module tpws_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input tpws_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_ready,
	input tpws_pkg::result_t result,
	input logic              pready
);
	import tpws_pkg::*;

	logic item_acc;
	logic read_acc_free;

	assign item_acc      = item_valid & item_ready;
	assign read_acc_free = item_acc & (item.mode == MODE_READ) & ~result_valid;

	// stalled result holds
	`TPWS_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result))
	// zero wait states on the register port
	`TPWS_ASSERT_IMP(a_pready_high, clk, arst_n, 1'b1, pready)
	// one request at a time
	`TPWS_ASSERT_NXT(a_busy_after_accept, clk, arst_n, item_acc, !item_ready)
	// a read accepted while no result is pending raises result_valid after dispatch and the read state
	`TPWS_ASSERT_NXT(a_read_latency, clk, arst_n, read_acc_free, ##2 result_valid)

endmodule

bind tooth_period_wheel_speed_unit tpws_checker u_tpws_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result),
	.pready       (pready)
);

// ----- tb/tb_tooth_period_wheel_speed_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tooth period wheel speed unit: testbench
// Runs a short directed script, then random capture/read traffic under several
// register settings. Every speed read is predicted in the bench and checked
// field by field in order; both the request side and the result side stall at random.
// ----------------------------------------------------------------------------
module tb_tooth_period_wheel_speed_unit;
	import tpws_pkg::*;

	localparam int SETTLE_CYCLES = 64;   // outlasts the longest capture, a full division
	localparam int LONG_HOLD     = 300;
	localparam int MAX_REPORTS   = 10;

	typedef struct {
		item_t       it;
		bit          typed;
		logic [31:0] speed;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_ready;
	item_t                 item;
	logic                  result_valid;
	logic                  result_ready;
	result_t               result;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_W-1:0]     paddr;
	logic [DATA_W-1:0]     pwdata;
	logic [DATA_W-1:0]     prdata;
	logic                  pready;

	// bench copy of the per-wheel state and the registers
	logic [CAP_W-1:0]   p_last_capture [NUM_WHEELS];
	bit                 p_first_pending [NUM_WHEELS];
	logic [MS_W-1:0]    p_tooth_ms [NUM_WHEELS];
	logic [SPEED_W-1:0] p_speed [NUM_WHEELS];
	logic [31:0]        c_tpm;
	logic [31:0]        c_teeth;
	logic [31:0]        c_max_gap;
	logic [31:0]        c_standstill;

	result_t expected_speeds [$];
	int      mismatch_count;
	bit      idling_on;
	bit      rx_long_hold;

	// reset-value rows; typed speeds are the obvious ones
	dir_row_t directed_steps [19] = '{
		'{'{MODE_READ,    1'b0, 16'h0000, 32'd0},          1'b1, 32'd0},
		'{'{MODE_READ,    1'b0, 16'hFFFF, 32'hFFFF_FFFF},  1'b1, 32'd0},
		'{'{MODE_READ,    1'b1, 16'h1234, 32'd300},        1'b1, 32'd0},
		'{'{MODE_CAPTURE, 1'b0, 16'd0,    32'd1000},       1'b0, 32'd0},
		'{'{MODE_CAPTURE, 1'b0, 16'd1000, 32'd1010},       1'b0, 32'd0},
		'{'{MODE_READ,    1'b0, 16'd0,    32'd1010},       1'b1, 32'd48000},
		'{'{MODE_CAPTURE, 1'b0, 16'd1000, 32'd1020},       1'b0, 32'd0},
		'{'{MODE_READ,    1'b0, 16'd0,    32'd1020},       1'b1, 32'd48000},
		'{'{MODE_CAPTURE, 1'b0, 16'd999,  32'd1030},       1'b0, 32'd0},
		'{'{MODE_READ,    1'b0, 16'd0,    32'd1330},       1'b0, 32'd0},
		'{'{MODE_READ,    1'b0, 16'd0,    32'd1331},       1'b1, 32'd0},
		'{'{MODE_CAPTURE, 1'b0, 16'd2000, 32'd1091},       1'b0, 32'd0},
		'{'{MODE_READ,    1'b0, 16'd0,    32'd1091},       1'b1, 32'd0},
		'{'{MODE_CAPTURE, 1'b0, 16'd2001, 32'd1151},       1'b0, 32'd0},
		'{'{MODE_READ,    1'b0, 16'd0,    32'd1151},       1'b1, 32'd48000000},
		'{'{MODE_CAPTURE, 1'b1, 16'hFFFF, 32'hFFFF_FFF0},  1'b0, 32'd0},
		'{'{MODE_CAPTURE, 1'b1, 16'h0000, 32'h0000_0010},  1'b0, 32'd0},
		'{'{MODE_READ,    1'b1, 16'd0,    32'h0000_0020},  1'b0, 32'd0},
		'{'{MODE_READ,    1'b1, 16'hFFFF, 32'h0000_0010},  1'b0, 32'd0}
	};

	tooth_period_wheel_speed_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

	// Returns 1 when the request yields a speed, with that speed in r.
	function automatic bit predict_speed(input item_t it, output result_t r);
		logic [31:0] gap;
		logic [15:0] delta;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] quo;
		logic        w;
		r = '0;
		w = it.wheel_index;
		if (it.mode == MODE_CAPTURE) begin
			if (int'(w) < NUM_WHEELS) begin
				gap = it.now_ms - p_tooth_ms[w];
				if (p_first_pending[w] || gap > c_max_gap) begin
					p_first_pending[w] = 1'b0;
					p_speed[w] = '0;
				end else begin
					delta = it.capture_value - p_last_capture[w];
					num = 64'(c_tpm) << SPEED_FRAC_BITS;
					den = 64'(c_teeth) * 64'(delta);
					// zero delta or zero teeth keeps the old speed
					if (den != 64'd0) begin
						quo = num / den;
						p_speed[w] = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
					end
				end
				p_last_capture[w] = it.capture_value;
				p_tooth_ms[w] = it.now_ms;
			end
			return 1'b0;
		end
		r.speed_wheel = it.wheel_index;
		if (int'(w) < NUM_WHEELS && (it.now_ms - p_tooth_ms[w]) <= c_standstill)
			r.speed_sixteenths = p_speed[w];
		return 1'b1;
	endfunction

	// Mostly well-formed tooth trains and reads near the current time, some noise.
	function automatic item_t make_item();
		item_t       it;
		logic        w;
		int          kind;
		int          pick;
		logic [15:0] delta;
		w = 1'($urandom_range(0, NUM_WHEELS - 1));
		kind = $urandom_range(0, 9);
		it.wheel_index = w;
		it.capture_value = 16'($urandom());
		it.now_ms = $urandom();
		if (kind < 2) begin
			it.mode = 1'($urandom_range(0, 1));
		end else if (kind < 6) begin
			it.mode = MODE_CAPTURE;
			pick = $urandom_range(0, 9);
			if (pick == 0)
				delta = '0;
			else if (pick < 5)
				delta = 16'($urandom_range(1, 64));
			else
				delta = 16'($urandom_range(1, 65535));
			it.capture_value = p_last_capture[w] + delta;
			if ($urandom_range(0, 7) == 0)
				it.now_ms = p_tooth_ms[w] + c_max_gap + $urandom_range(1, 3);
			else
				it.now_ms = p_tooth_ms[w] + $urandom_range(0, c_max_gap);
		end else begin
			it.mode = MODE_READ;
			it.now_ms = p_tooth_ms[w] + $urandom_range(0, c_standstill + 3);
		end
		return it;
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
				$realtime, what, want, want, got, got);
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_speeds.size() == 0) begin
				note_mismatch("unexpected speed", 32'd0, result.speed_sixteenths);
			end else begin
				want = expected_speeds.pop_front();
				if (result.speed_sixteenths !== want.speed_sixteenths)
					note_mismatch("speed", want.speed_sixteenths, result.speed_sixteenths);
				if (result.speed_wheel !== want.speed_wheel)
					note_mismatch("wheel", 32'(want.speed_wheel), 32'(result.speed_wheel));
			end
		end
	end

	// result side: random stalls plus one long hold on request
	initial begin
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_long_hold) begin
				result_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				rx_long_hold = 1'b0;
			end
			if (idling_on && $urandom_range(0, 7) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			result_ready <= 1'b1;
		end
	end

	task automatic send(input item_t it, input bit typed, input logic [31:0] typed_speed);
		result_t r;
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		if (predict_speed(it, r)) begin
			if (typed)
				r.speed_sixteenths = typed_speed;
			expected_speeds.push_back(r);
		end
		if (idling_on && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic wait_for_results(input bit settle);
		item_valid <= 1'b0;
		while (expected_speeds.size() != 0) @(posedge clk);
		// a capture may still be dividing after the last read came back
		if (settle)
			repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic apply_cfg(input cfg_t c);
		apb_write(REG_TICKS_PER_MINUTE, DATA_W'(c.ticks_per_minute));
		apb_write(REG_TEETH_COUNT, DATA_W'(c.teeth_count));
		apb_write(REG_MAX_GAP_MS, DATA_W'(c.max_gap_ms));
		apb_write(REG_STANDSTILL_MS, DATA_W'(c.standstill_ms));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		c_tpm = 32'(c.ticks_per_minute);
		c_teeth = 32'(c.teeth_count);
		c_max_gap = 32'(c.max_gap_ms);
		c_standstill = 32'(c.standstill_ms);
		@(posedge clk);
	endtask

	function automatic cfg_t make_cfg();
		cfg_t c;
		c.ticks_per_minute = TPM_W'($urandom_range(1, (1 << TPM_W) - 1));
		c.teeth_count = TEETH_W'($urandom_range(1, 255));
		c.max_gap_ms = MS_CFG_W'($urandom_range(0, 1) ? $urandom_range(0, 300)
			: $urandom_range(0, 65535));
		c.standstill_ms = MS_CFG_W'($urandom_range(0, 1) ? $urandom_range(0, 600)
			: $urandom_range(0, 65535));
		return c;
	endfunction

	task automatic run_random(input int count);
		for (int n = 0; n < count; n++) begin
			if (n == count / 2)
				wait_for_results(1'b0);
			send(make_item(), 1'b0, '0);
		end
	endtask

	initial begin
		cfg_t c;
		item_t rd;
		int    tail;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		mismatch_count = 0;
		idling_on = 1'b1;
		rx_long_hold = 1'b0;
		c_tpm = 32'(RST_TICKS_PER_MINUTE);
		c_teeth = 32'(RST_TEETH_COUNT);
		c_max_gap = 32'(RST_MAX_GAP_MS);
		c_standstill = 32'(RST_STANDSTILL_MS);
		for (int i = 0; i < NUM_WHEELS; i++) begin
			p_last_capture[i] = '0;
			p_first_pending[i] = 1'b1;
			p_tooth_ms[i] = '0;
			p_speed[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i])
			send(directed_steps[i].it, directed_steps[i].typed, directed_steps[i].speed);
		wait_for_results(1'b1);

		// extremes: widest measuring window, then the narrowest
		apply_cfg('{28'hFFF_FFFF, 8'd1, 16'hFFFF, 16'hFFFF});
		run_random(150);
		wait_for_results(1'b1);
		apply_cfg('{28'd1, 8'd255, 16'd0, 16'd0});
		run_random(100);
		wait_for_results(1'b1);

		// zero teeth: every measured capture keeps the old speed
		apply_cfg('{RST_TICKS_PER_MINUTE, 8'd0, RST_MAX_GAP_MS, RST_STANDSTILL_MS});
		run_random(50);
		wait_for_results(1'b1);

		for (int p = 0; p < 6; p++) begin
			idling_on = $urandom_range(0, 3) != 0;
			apply_cfg(make_cfg());
			if (p == 0) begin
				// hold results back while reads pile up behind the output register
				idling_on = 1'b0;
				rx_long_hold = 1'b1;
				for (int k = 0; k < 12; k++) begin
					rd = make_item();
					rd.mode = MODE_READ;
					send(rd, 1'b0, '0);
				end
				idling_on = 1'b1;
			end
			run_random(125);
			wait_for_results(1'b1);
		end

		// closing stretch at reset values, no stalls anywhere
		idling_on = 1'b0;
		apply_cfg('{RST_TICKS_PER_MINUTE, RST_TEETH_COUNT, RST_MAX_GAP_MS, RST_STANDSTILL_MS});
		run_random(150);

		item_valid <= 1'b0;
		tail = 0;
		while (expected_speeds.size() != 0 && tail < 20000) begin
			@(posedge clk);
			tail++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_speeds.size() != 0)
			$display("%0d speed results never arrived", expected_speeds.size());
		if (mismatch_count == 0 && expected_speeds.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
